// ===== hw/rtl/slzw_pkg.sv =====
package slzw_pkg;

    // commands to the bit packer
    typedef struct packed {
        logic clear;   // empty the accumulator
        logic put;     // append a code at the current fill
        logic shift;   // drop the lowest byte
    } pack_cmd_t;

    // packer status back to the sequencer
    typedef struct packed {
        logic byte_ready;  // at least eight bits held
        logic partial;     // some bits held
    } pack_stat_t;

    localparam int PEND_DEPTH = 4;
    localparam int PEND_IW    = 2;
    localparam int PEND_CW    = 3;
    localparam int ROOTS      = 256;
    localparam int START_CW   = 9;
    localparam int TOTAL_MAX  = 65535;

endpackage

// ===== hw/rtl/slzw_minicache_compressor.sv =====
// LZW byte compressor with a direct-mapped cache of recently sent codes.
// Input channel s_*: one raw byte per transaction, s_tlast marks the last byte
// of a block (a block also closes by itself at BLOCK_BYTES bytes).
// Output channel m_*: packed bytes; the first byte of a block is a header equal
// to CACHE_SLOTS mod 256. m_tlast marks the last byte caused by one input byte,
// m_tuser[0] is set on the bytes of the closing step, m_tuser[1] when the packed
// block is larger than raw; on them m_tdata[23:8] holds the block byte count (raw+1 if larger).
// cfg_wr_en/cfg_wr_data: 1 also caches each new dictionary code; write while idle.
// Each byte runs through a sequencer over dictionary memories with registered
// reads: a child read and check, a read and check per trie node visited, then,
// when a code is sent, a cache read and check (and a write of the newest code
// when new codes also enter the cache), pack, then drain and output register per
// output byte; a closing byte also packs its final code and flushes, and every
// byte then returns to idle before the next accept. A block's first byte packs the header instead of the trie steps.
// One byte is handled at a time; s_tready is high only between bytes.
// The output register lets the next byte be taken while the final result
// still waits; a stalled receiver holds the sequencer in its output phase.
// Reset (synchronous, aresetn low) empties the output and starts a new block;
// root links and cache slots are cleared by valid bits, no clearing pass.
module slzw_minicache_compressor #(
    parameter int DICT_ENTRIES = 512,
    parameter int CACHE_SLOTS  = 32,
    parameter int BLOCK_BYTES  = 528
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], out_total[23:8]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // block_done[0], expanded[1]
);
    import slzw_pkg::*;

    localparam int CW    = $clog2(DICT_ENTRIES);
    localparam int NF_W  = CW + 1;
    localparam int CWW   = $clog2(CW + 1);
    localparam int IDX_W = $clog2(CACHE_SLOTS);
    localparam int HW    = IDX_W + 1;
    localparam int VAL_W = CW + 1;
    localparam int N_W   = $clog2(VAL_W + 1);
    localparam int BC_RAW = $clog2(BLOCK_BYTES * (CW + 1) / 8 + 8) + 1;
    localparam int BC_W  = (BC_RAW > 17) ? BC_RAW : 17;

    typedef enum logic [3:0] {
        S_IDLE, S_CHILD_RD, S_CHILD_CHK, S_WALK_RD, S_WALK_CHK, S_CREATE,
        S_CACHE_RD, S_CACHE_CHK, S_NEWEST, S_PACK, S_DRAIN, S_FLUSH, S_OUT
    } state_t;

    state_t            state_reg;
    logic              cache_new_reg;
    logic              block_start_reg;
    logic [7:0]        char_reg;
    logic              last_reg;
    logic              final_reg;
    logic              added_reg;
    logic              done_reg;
    logic [CW-1:0]     cur_reg;
    logic [CW-1:0]     node_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [CWW-1:0]    cw_reg;
    logic [15:0]       in_count_reg;
    logic [BC_W-1:0]   bc_reg;
    logic [ROOTS-1:0]  root_valid_reg;
    logic [CACHE_SLOTS-1:0] cache_valid_reg;
    logic [VAL_W-1:0]  put_val_reg;
    logic [N_W-1:0]    put_n_reg;
    logic [7:0]        pend_reg [PEND_DEPTH];
    logic [PEND_CW-1:0] np_reg;
    logic [PEND_CW-1:0] oi_reg;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;
    logic              m_last_reg;
    logic [1:0]        m_user_reg;

    pack_cmd_t  pcmd;
    pack_stat_t pstat;
    logic [7:0] low_byte;

    // dictionary and cache memories
    logic            child_we, sib_we, char_we, cache_we;
    logic [CW-1:0]   child_wa, child_wd, sib_wa, sib_wd, char_wa, cache_wd;
    logic [IDX_W-1:0] cache_wa;
    logic [CW-1:0]   child_q, sib_q, cache_q;
    logic [7:0]      char_q;

    slzw_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_child (
        .aclk(aclk), .we(child_we), .waddr(child_wa), .wdata(child_wd),
        .raddr(cur_reg), .rdata(child_q));
    slzw_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_sib (
        .aclk(aclk), .we(sib_we), .waddr(sib_wa), .wdata(sib_wd),
        .raddr(node_reg), .rdata(sib_q));
    slzw_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_char (
        .aclk(aclk), .we(char_we), .waddr(char_wa), .wdata(char_reg),
        .raddr(node_reg), .rdata(char_q));
    slzw_ram #(.WIDTH(CW), .DEPTH(CACHE_SLOTS)) u_cache (
        .aclk(aclk), .we(cache_we), .waddr(cache_wa), .wdata(cache_wd),
        .raddr(cur_reg[IDX_W-1:0]), .rdata(cache_q));

    slzw_bitpack #(.VAL_W(VAL_W), .N_W(N_W)) u_pack (
        .aclk(aclk), .aresetn(aresetn), .cmd(pcmd), .put_val(put_val_reg),
        .put_n(put_n_reg), .stat(pstat), .low_byte(low_byte));

    // derived values
    logic            nf_room;
    logic [CW-1:0]   nf_code;
    logic [CW-1:0]   newest;
    logic [CW-1:0]   child_eff;
    logic            child_none;
    logic            sib_more;
    logic [IDX_W-1:0] cidx;
    logic [CW-1:0]   slot_val;
    logic            hit;
    logic [15:0]     in_next;
    logic            last_eff;
    logic            expanded;
    logic [BC_W-1:0] total_raw;
    logic [15:0]     total;
    logic            accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign nf_room  = (nf_reg < NF_W'(DICT_ENTRIES));
    assign nf_code  = nf_reg[CW-1:0];
    assign newest   = CW'(nf_reg - NF_W'(1));
    assign child_eff = (cur_reg < CW'(ROOTS) && !root_valid_reg[cur_reg[7:0]])
                       ? '0 : child_q;
    assign child_none = (child_eff == '0) ||
                        ({1'b0, child_eff} >= NF_W'(DICT_ENTRIES));
    assign sib_more = (sib_q != '0) && ({1'b0, sib_q} < NF_W'(DICT_ENTRIES));
    assign cidx     = cur_reg[IDX_W-1:0];
    assign slot_val = cache_valid_reg[cidx] ? cache_q : CW'(cidx);
    assign hit      = (slot_val == cur_reg);
    assign in_next  = block_start_reg ? 16'd1 :
                      (in_count_reg < 16'hFFFF) ? in_count_reg + 16'd1 : in_count_reg;
    assign last_eff = s_tlast || (in_next >= 16'(BLOCK_BYTES));
    assign expanded = bc_reg > BC_W'(in_count_reg);
    assign total_raw = expanded ? BC_W'(in_count_reg) + BC_W'(1) : bc_reg;
    assign total    = (total_raw > BC_W'(TOTAL_MAX)) ? 16'(TOTAL_MAX) : total_raw[15:0];

    // memory write selection
    always_comb begin
        child_we = 1'b0; child_wa = cur_reg; child_wd = nf_code;
        sib_we   = 1'b0; sib_wa   = node_reg; sib_wd  = nf_code;
        char_we  = 1'b0; char_wa  = nf_code;
        cache_we = 1'b0; cache_wa = cidx; cache_wd = cur_reg;
        unique case (state_reg)
            S_CHILD_CHK: child_we = child_none && nf_room;
            S_WALK_CHK: sib_we = (char_q != char_reg) && !sib_more && nf_room;
            S_CREATE: begin
                child_we = nf_room; child_wa = nf_code; child_wd = '0;
                sib_we   = nf_room; sib_wa   = nf_code; sib_wd   = '0;
                char_we  = nf_room;
            end
            S_CACHE_CHK: cache_we = !hit && !final_reg;
            S_NEWEST: begin
                cache_we = 1'b1;
                cache_wa = newest[IDX_W-1:0];
                cache_wd = newest;
            end
            default: ;
        endcase
    end

    // packer commands
    always_comb begin
        pcmd = '0;
        unique case (state_reg)
            S_IDLE:  pcmd.clear = accept && block_start_reg;
            S_PACK:  pcmd.put   = 1'b1;
            S_DRAIN: pcmd.shift = pstat.byte_ready;
            S_FLUSH: pcmd.clear = 1'b1;
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cache_new_reg   <= 1'b0;
            block_start_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
            root_valid_reg  <= '0;
            cache_valid_reg <= '0;
            cur_reg         <= '0;
            nf_reg          <= NF_W'(ROOTS);
            cw_reg          <= CWW'(START_CW);
            in_count_reg    <= '0;
            bc_reg          <= '0;
            np_reg          <= '0;
            oi_reg          <= '0;
            done_reg        <= 1'b0;
            final_reg       <= 1'b0;
            last_reg        <= 1'b0;
            added_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cache_new_reg <= cfg_wr_data;
            end
            // output register empties outside the output phase
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        char_reg     <= s_tdata;
                        last_reg     <= last_eff;
                        final_reg    <= 1'b0;
                        added_reg    <= 1'b0;
                        done_reg     <= 1'b0;
                        np_reg       <= '0;
                        oi_reg       <= '0;
                        in_count_reg <= in_next;
                        if (block_start_reg) begin
                            // new block: header byte, fresh dictionary
                            block_start_reg <= 1'b0;
                            root_valid_reg  <= '0;
                            cache_valid_reg <= '0;
                            nf_reg          <= NF_W'(ROOTS);
                            cw_reg          <= CWW'(START_CW);
                            bc_reg          <= '0;
                            cur_reg         <= CW'(s_tdata);
                            put_val_reg     <= VAL_W'(CACHE_SLOTS & 8'hFF);
                            put_n_reg       <= N_W'(8);
                            state_reg       <= S_PACK;
                        end else begin
                            state_reg <= S_CHILD_RD;
                        end
                    end
                end
                S_CHILD_RD: state_reg <= S_CHILD_CHK;
                S_CHILD_CHK: begin
                    if (child_none) begin
                        if (nf_room && cur_reg < CW'(ROOTS)) begin
                            root_valid_reg[cur_reg[7:0]] <= 1'b1;
                        end
                        state_reg <= S_CREATE;
                    end else begin
                        node_reg  <= child_eff;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_RD: state_reg <= S_WALK_CHK;
                S_WALK_CHK: begin
                    if (char_q == char_reg) begin
                        // string extends: no code this byte unless it is the last
                        cur_reg <= node_reg;
                        if (last_reg) begin
                            final_reg <= 1'b1;
                            state_reg <= S_CACHE_RD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else if (sib_more) begin
                        node_reg  <= sib_q;
                        state_reg <= S_WALK_RD;
                    end else begin
                        state_reg <= S_CREATE;
                    end
                end
                S_CREATE: begin
                    if (nf_room) begin
                        nf_reg    <= nf_reg + NF_W'(1);
                        added_reg <= 1'b1;
                    end
                    state_reg <= S_CACHE_RD;
                end
                S_CACHE_RD: state_reg <= S_CACHE_CHK;
                S_CACHE_CHK: begin
                    if (hit) begin
                        put_val_reg <= VAL_W'({cidx, 1'b1});
                        put_n_reg   <= N_W'(HW);
                    end else begin
                        put_val_reg <= {cur_reg, 1'b0};
                        put_n_reg   <= N_W'(cw_reg) + N_W'(1);
                        if (!final_reg) begin
                            cache_valid_reg[cidx] <= 1'b1;
                        end
                    end
                    if (!final_reg) begin
                        cur_reg <= CW'(char_reg);
                        if ((newest >> cw_reg) != '0) begin
                            cw_reg <= cw_reg + CWW'(1);
                        end
                    end
                    state_reg <= (!final_reg && added_reg && cache_new_reg)
                                 ? S_NEWEST : S_PACK;
                end
                S_NEWEST: begin
                    cache_valid_reg[newest[IDX_W-1:0]] <= 1'b1;
                    state_reg <= S_PACK;
                end
                S_PACK: state_reg <= S_DRAIN;
                S_DRAIN: begin
                    if (pstat.byte_ready) begin
                        pend_reg[np_reg[PEND_IW-1:0]] <= low_byte;
                        np_reg <= np_reg + PEND_CW'(1);
                        bc_reg <= bc_reg + BC_W'(1);
                    end else if (final_reg) begin
                        state_reg <= S_FLUSH;
                    end else if (last_reg) begin
                        final_reg <= 1'b1;
                        state_reg <= S_CACHE_RD;
                    end else begin
                        state_reg <= (np_reg != '0) ? S_OUT : S_IDLE;
                    end
                end
                S_FLUSH: begin
                    // partial byte with zero upper bits, block closes
                    if (pstat.partial) begin
                        pend_reg[np_reg[PEND_IW-1:0]] <= low_byte;
                        np_reg <= np_reg + PEND_CW'(1);
                        bc_reg <= bc_reg + BC_W'(1);
                    end
                    done_reg        <= 1'b1;
                    block_start_reg <= 1'b1;
                    state_reg       <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {done_reg ? total : 16'd0,
                                        pend_reg[oi_reg[PEND_IW-1:0]]};
                        m_last_reg  <= (oi_reg + PEND_CW'(1) == np_reg);
                        m_user_reg  <= {done_reg && expanded, done_reg};
                        oi_reg      <= oi_reg + PEND_CW'(1);
                        if (oi_reg + PEND_CW'(1) == np_reg) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        np_reg <= PEND_CW'(PEND_DEPTH))
        else $error("pending byte count overflow");
    a_out_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT |-> np_reg != '0)
        else $error("output phase with no bytes");
    a_cache_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CACHE_CHK |-> $past(state_reg) == S_CACHE_RD)
        else $error("cache check without read");
    a_last_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && oi_reg + PEND_CW'(1) == np_reg &&
        (!m_valid_reg || m_tready) |=> m_tlast && s_tready)
        else $error("closing byte not tagged");
`endif

endmodule

// ===== hw/rtl/slzw_ram.sv =====
module slzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/slzw_bitpack.sv =====
module slzw_bitpack #(
    parameter int VAL_W = 10,
    parameter int N_W   = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  slzw_pkg::pack_cmd_t cmd,
    input  logic [VAL_W-1:0]   put_val,
    input  logic [N_W-1:0]     put_n,
    output slzw_pkg::pack_stat_t stat,
    output logic [7:0]         low_byte
);
    import slzw_pkg::*;

    localparam int ACC_W  = VAL_W + 8;
    localparam int FILL_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  acc_reg;
    logic [FILL_W-1:0] fill_reg;

    // shared shifter: clear, append at the fill point or drop one byte
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end else if (cmd.put) begin
            acc_reg  <= acc_reg | (ACC_W'(put_val) << fill_reg);
            fill_reg <= fill_reg + FILL_W'(put_n);
        end else if (cmd.shift) begin
            acc_reg  <= acc_reg >> 8;
            fill_reg <= fill_reg - FILL_W'(8);
        end
    end

    assign stat.byte_ready = (fill_reg >= FILL_W'(8));
    assign stat.partial    = (fill_reg != '0);
    assign low_byte        = acc_reg[7:0];

endmodule
